/* rtl/ftc_pkg.sv */
// Shared types and constants of the filmic tone curve unit.
// No dependencies; ftc_cfg, ftc_front and the top level refer to it by scoped names.
package ftc_pkg;

	// coefficient and register port formats
	localparam int COEF_W     = 16;
	localparam int WHITE_W    = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SHOULDER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_STR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_ANG  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOE_STR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOE_NUM  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOE_DEN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE    = 3'd6;

	// register reset values
	localparam logic [COEF_W-1:0]  A_RST     = 16'd614;
	localparam logic [COEF_W-1:0]  B_RST     = 16'd2048;
	localparam logic [COEF_W-1:0]  C_RST     = 16'd410;
	localparam logic [COEF_W-1:0]  D_RST     = 16'd819;
	localparam logic [COEF_W-1:0]  E_RST     = 16'd82;
	localparam logic [COEF_W-1:0]  F_RST     = 16'd1229;
	localparam logic [WHITE_W-1:0] WHITE_RST = 24'd734003;

	// numerator / denominator and ratio formats
	localparam int PQ_W       = 64;
	localparam int RATIO_FRAC = 24;
	localparam int RATIO_B    = 56;
	localparam int SPLIT      = RATIO_B - RATIO_FRAC;
	localparam int OFS_W      = COEF_W + RATIO_FRAC;
	localparam int F_W        = RATIO_B + 2;
	localparam int MAG_W      = F_W - 1;
	localparam int LANES      = 4;
	localparam int PROD_W     = 2 * COEF_W;

	typedef logic [PQ_W-1:0]  pq_t;
	typedef logic [F_W-1:0]   fval_t;
	typedef logic [MAG_W-1:0] mag_t;

	// coefficients and derived constants seen by the datapath
	typedef struct packed {
		logic [COEF_W-1:0] a;
		logic [COEF_W-1:0] b;
		logic [COEF_W-1:0] c;
		logic [COEF_W-1:0] d;
		logic [COEF_W-1:0] e;
		logic [COEF_W-1:0] f;
		logic [PROD_W-1:0] cb;
		logic [PROD_W-1:0] de;
		logic [PROD_W-1:0] df;
		logic [OFS_W-1:0]  ofs;
		logic              f_zero;
	} coef_t;

endpackage

/* rtl/ftc_cfg.sv */
// Configuration registers, coefficient products and the E/F offset divider.
// Depends on ftc_pkg.
module ftc_cfg #(
	parameter int IN_W = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [ftc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ftc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output ftc_pkg::coef_t                      coef,
	output logic [IN_W-1:0]                     white
);

	typedef logic [IN_W-1:0] white_t;
	localparam int CNT_W = $clog2(ftc_pkg::OFS_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ftc_pkg::OFS_W - 1);

	logic [ftc_pkg::COEF_W-1:0] a_q, b_q, c_q, d_q, e_q, f_q;
	white_t                     white_q;
	logic [ftc_pkg::PROD_W-1:0] cb_q, de_q, df_q;
	logic                       start_q, busy_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ftc_pkg::COEF_W-1:0] rem_q;
	logic [ftc_pkg::OFS_W-1:0]  num_q, quo_q, ofs_q;
	logic [ftc_pkg::COEF_W:0]   part, diff;
	logic                       ge;

	// register writes and divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q     <= ftc_pkg::A_RST;
			b_q     <= ftc_pkg::B_RST;
			c_q     <= ftc_pkg::C_RST;
			d_q     <= ftc_pkg::D_RST;
			e_q     <= ftc_pkg::E_RST;
			f_q     <= ftc_pkg::F_RST;
			white_q <= white_t'(ftc_pkg::WHITE_RST);
			start_q <= 1'b1;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					ftc_pkg::REG_SHOULDER: a_q <= cfg_data[ftc_pkg::COEF_W-1:0];
					ftc_pkg::REG_LIN_STR:  b_q <= cfg_data[ftc_pkg::COEF_W-1:0];
					ftc_pkg::REG_LIN_ANG:  c_q <= cfg_data[ftc_pkg::COEF_W-1:0];
					ftc_pkg::REG_TOE_STR:  d_q <= cfg_data[ftc_pkg::COEF_W-1:0];
					ftc_pkg::REG_TOE_NUM:  e_q <= cfg_data[ftc_pkg::COEF_W-1:0];
					ftc_pkg::REG_TOE_DEN:  f_q <= cfg_data[ftc_pkg::COEF_W-1:0];
					ftc_pkg::REG_WHITE:    white_q <= white_t'(cfg_data);
					default: begin
					end
				endcase
			end
			// any write restarts the offset division
			if (cfg_valid) begin
				start_q <= 1'b1;
			end else if (start_q) begin
				start_q <= 1'b0;
			end
			if (start_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one offset quotient bit per cycle: (E << 24) / F
	assign part = {rem_q, num_q[ftc_pkg::OFS_W-1]};
	assign ge   = part >= {1'b0, f_q};
	assign diff = part - {1'b0, f_q};

	always_ff @(posedge clk) begin
		cb_q <= c_q * b_q;
		de_q <= d_q * e_q;
		df_q <= d_q * f_q;
		if (start_q) begin
			num_q <= {e_q, {ftc_pkg::RATIO_FRAC{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[ftc_pkg::COEF_W-1:0] : part[ftc_pkg::COEF_W-1:0];
			quo_q <= {quo_q[ftc_pkg::OFS_W-2:0], ge};
			if (cnt_q == CNT_LAST) begin
				ofs_q <= {quo_q[ftc_pkg::OFS_W-2:0], ge};
			end
		end
	end

	always_comb begin
		coef.a      = a_q;
		coef.b      = b_q;
		coef.c      = c_q;
		coef.d      = d_q;
		coef.e      = e_q;
		coef.f      = f_q;
		coef.cb     = cb_q;
		coef.de     = de_q;
		coef.df     = df_q;
		coef.ofs    = ofs_q;
		coef.f_zero = (f_q == '0);
	end

	assign white = white_q;

endmodule

/* rtl/ftc_front.sv */
// Curve front end for one lane: inner terms, split products, numerator and
// denominator over four pipeline stages. Depends on ftc_pkg.
module ftc_front #(
	parameter int IN_W = 24
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [IN_W-1:0]          x,
	input  ftc_pkg::coef_t           coef,
	output logic [ftc_pkg::PQ_W-1:0] p,
	output logic [ftc_pkg::PQ_W-1:0] q
);

	localparam int K    = ((73 - 2 * IN_W) < 28) ? (73 - 2 * IN_W) : 28;
	localparam int SH   = 28 - K;
	localparam int AX_W = IN_W + ftc_pkg::COEF_W;
	localparam int S_W  = ((AX_W > 36) ? AX_W : 36) + 1;
	localparam int U_W  = S_W - SH;
	localparam int LO   = U_W / 2;
	localparam int HI   = U_W - LO;

	typedef logic [AX_W-1:0]    ax_t;
	typedef logic [S_W-1:0]     sum_t;
	typedef logic [U_W-1:0]     u_t;
	typedef logic [IN_W+LO-1:0] plo_t;
	typedef logic [IN_W+HI-1:0] phi_t;

	ax_t             ax_s1;
	logic [IN_W-1:0] x_s1, x_s2;
	u_t              u_s2, v_s2;
	plo_t            pul_s3, pvl_s3;
	phi_t            puh_s3, pvh_s3;
	ftc_pkg::pq_t    p_s4, q_s4;
	sum_t            sum_u, sum_v;

	// inner sums A*x + C*B and A*x + B, cut to the inner fraction width
	assign sum_u = sum_t'(ax_s1) + sum_t'({coef.cb, 4'b0});
	assign sum_v = sum_t'(ax_s1) + sum_t'({coef.b, 16'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= ax_t'(coef.a) * ax_t'(x);
			x_s1   <= x;
			u_s2   <= u_t'(sum_u >> SH);
			v_s2   <= u_t'(sum_v >> SH);
			x_s2   <= x_s1;
			// x times inner term as two half products
			pul_s3 <= plo_t'(x_s2) * plo_t'(u_s2[LO-1:0]);
			puh_s3 <= phi_t'(x_s2) * phi_t'(u_s2[U_W-1:LO]);
			pvl_s3 <= plo_t'(x_s2) * plo_t'(v_s2[LO-1:0]);
			pvh_s3 <= phi_t'(x_s2) * phi_t'(v_s2[U_W-1:LO]);
			// recombine and add the toe terms, modulo 2^64
			p_s4   <= (ftc_pkg::pq_t'(puh_s3) << LO) + ftc_pkg::pq_t'(pul_s3)
				+ (ftc_pkg::pq_t'(coef.de) << (K - 8));
			q_s4   <= (ftc_pkg::pq_t'(pvh_s3) << LO) + ftc_pkg::pq_t'(pvl_s3)
				+ (ftc_pkg::pq_t'(coef.df) << (K - 8));
		end
	end

	assign p = p_s4;
	assign q = q_s4;

endmodule

/* rtl/ftc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with saturation
// when the starting remainder reaches the divisor. Depends on nothing.
module ftc_div #(
	parameter int D_W    = 64,
	parameter int Q_B    = 56,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [D_W-1:0]    rem0,
	input  logic [Q_B-1:0]    tail,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] side,
	output logic [Q_B-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);

	logic [D_W-1:0]    rem_s  [Q_B+1];
	logic [D_W-1:0]    den_s  [Q_B+1];
	logic [Q_B-1:0]    tail_s [Q_B+1];
	logic [Q_B-1:0]    quo_s  [Q_B+1];
	logic              sat_s  [Q_B+1];
	logic [SIDE_W-1:0] side_s [Q_B+1];

	// entry stage: saturation check
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= rem0;
			den_s[0]  <= den;
			tail_s[0] <= tail;
			quo_s[0]  <= '0;
			sat_s[0]  <= rem0 >= den;
			side_s[0] <= side;
		end
	end

	// one compare and subtract per stage
	for (genvar i = 0; i < Q_B; i++) begin : g_step
		logic [D_W:0] part;
		logic [D_W:0] diff;
		logic         ge;

		assign part = {rem_s[i], tail_s[i][Q_B-1]};
		assign ge   = part >= {1'b0, den_s[i]};
		assign diff = part - {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[D_W-1:0] : part[D_W-1:0];
				den_s[i+1]  <= den_s[i];
				tail_s[i+1] <= tail_s[i] << 1;
				quo_s[i+1]  <= {quo_s[i][Q_B-2:0], ge};
				sat_s[i+1]  <= sat_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign quo      = sat_s[Q_B] ? '1 : quo_s[Q_B];
	assign side_out = side_s[Q_B];

endmodule

/* rtl/filmic_tone_curve_rgb_unit.sv */
// Top level of the filmic tone curve unit: white point and three color lanes.
// Depends on ftc_pkg, ftc_cfg, ftc_front and ftc_div.
//
// Takes one RGB pixel per clock while the output buffer is not full and gives
// one result per pixel, in order. Results pass through the pipeline and then
// the two-beat output buffer. The depth is set by the ratio divider (one
// quotient bit per stage, 56 bits) and the output divider (OUT_WIDTH bits). The
// whole pipeline stalls only when two results wait at the output. The white
// point goes down its own lane with every pixel. E/F is divided bit-serially
// after reset and after every register write; the pipeline depth hides the
// division time.
module filmic_tone_curve_rgb_unit #(
	parameter int IN_WIDTH  = 24,
	parameter int OUT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input pixel beat
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [((3*IN_WIDTH+7)/8)*8-1:0]    s_tdata,  // red_in, green_in, blue_in
	// result beat
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [((3*OUT_WIDTH+7)/8)*8-1:0]   m_tdata,  // red_out, green_out, blue_out
	output logic                               m_tuser,  // div_fault
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ftc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ftc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int M_TDATA_W = ((3 * OUT_WIDTH + 7) / 8) * 8;
	localparam int PIPE_LAT  = 4 + (ftc_pkg::RATIO_B + 1) + 2 + (OUT_WIDTH + 1);
	localparam int WORD_W    = 3 * OUT_WIDTH + 1;

	typedef logic [M_TDATA_W-1:0] mt_t;
	typedef logic [OUT_WIDTH-1:0] out_t;

	ftc_pkg::coef_t        coef;
	logic [IN_WIDTH-1:0]   white;
	logic                  en;
	logic [PIPE_LAT-1:0]   vld_q;

	logic [IN_WIDTH-1:0]     lane_x [ftc_pkg::LANES];
	logic [ftc_pkg::PQ_W-1:0] p_l   [ftc_pkg::LANES];
	logic [ftc_pkg::PQ_W-1:0] q_l   [ftc_pkg::LANES];
	logic [ftc_pkg::RATIO_B-1:0] r_l [ftc_pkg::LANES];
	logic                    qz_l   [ftc_pkg::LANES];

	ftc_pkg::fval_t crv_s1 [ftc_pkg::LANES];
	logic           qz_s1, fz_s1;
	ftc_pkg::mag_t  mag_s2 [3];
	logic           zero_s2 [3];
	ftc_pkg::mag_t  magw_s2;
	logic           bad_s2;

	out_t       sq_l   [3];
	logic [1:0] sside_l [3];
	out_t       res_c  [3];

	logic [WORD_W-1:0] mem_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push, pop;
	logic [WORD_W-1:0] rd_word;

	// registers
	ftc_cfg #(.IN_W(IN_WIDTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef),
		.white     (white)
	);
	assign cfg_ready = 1'b1;

	// global advance: stalls only with a full output buffer
	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_tvalid};
		end
	end

	// lane 0 carries the white point, lanes 1..3 red, green, blue
	assign lane_x[0] = white;
	for (genvar c = 0; c < 3; c++) begin : g_in
		assign lane_x[c+1] = s_tdata[c*IN_WIDTH +: IN_WIDTH];
	end

	for (genvar l = 0; l < ftc_pkg::LANES; l++) begin : g_lane
		ftc_front #(.IN_W(IN_WIDTH)) u_front (
			.clk  (clk),
			.en   (en),
			.x    (lane_x[l]),
			.coef (coef),
			.p    (p_l[l]),
			.q    (q_l[l])
		);

		ftc_div #(
			.D_W    (ftc_pkg::PQ_W),
			.Q_B    (ftc_pkg::RATIO_B),
			.SIDE_W (1)
		) u_ratio (
			.clk      (clk),
			.en       (en),
			.rem0     (ftc_pkg::pq_t'(p_l[l][ftc_pkg::PQ_W-1:ftc_pkg::SPLIT])),
			.tail     ({p_l[l][ftc_pkg::SPLIT-1:0], {ftc_pkg::RATIO_FRAC{1'b0}}}),
			.den      (q_l[l]),
			.side     (q_l[l] == '0),
			.quo      (r_l[l]),
			.side_out (qz_l[l])
		);
	end

	// curve value f = r - E/F, and fault sources
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < ftc_pkg::LANES; l++) begin
				crv_s1[l] <= ftc_pkg::fval_t'(r_l[l]) - ftc_pkg::fval_t'(coef.ofs);
			end
			qz_s1 <= qz_l[0] | qz_l[1] | qz_l[2] | qz_l[3];
			fz_s1 <= coef.f_zero;
		end
	end

	// magnitudes and sign checks against the white curve value
	always_ff @(posedge clk) begin
		if (en) begin
			bad_s2  <= fz_s1 | qz_s1 | (crv_s1[0] == '0);
			magw_s2 <= crv_s1[0][ftc_pkg::F_W-1]
				? ftc_pkg::mag_t'(~crv_s1[0] + 1'b1) : ftc_pkg::mag_t'(crv_s1[0]);
			for (int c = 0; c < 3; c++) begin
				zero_s2[c] <= (crv_s1[c+1] == '0)
					| (crv_s1[c+1][ftc_pkg::F_W-1] != crv_s1[0][ftc_pkg::F_W-1]);
				mag_s2[c]  <= crv_s1[c+1][ftc_pkg::F_W-1]
					? ftc_pkg::mag_t'(~crv_s1[c+1] + 1'b1)
					: ftc_pkg::mag_t'(crv_s1[c+1]);
			end
		end
	end

	// scale by the white curve value
	for (genvar c = 0; c < 3; c++) begin : g_scale
		ftc_div #(
			.D_W    (ftc_pkg::MAG_W),
			.Q_B    (OUT_WIDTH),
			.SIDE_W (2)
		) u_scale (
			.clk      (clk),
			.en       (en),
			.rem0     (mag_s2[c]),
			.tail     ('0),
			.den      (magw_s2),
			.side     ({bad_s2, zero_s2[c]}),
			.quo      (sq_l[c]),
			.side_out (sside_l[c])
		);
		assign res_c[c] = (sside_l[c][1] | sside_l[c][0]) ? '0 : sq_l[c];
	end

	// two-beat output buffer
	assign push    = en & vld_q[PIPE_LAT-1];
	assign pop     = m_tvalid & m_tready;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= {sside_l[0][1], res_c[2], res_c[1], res_c[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = mt_t'(rd_word[3*OUT_WIDTH-1:0]);
	assign m_tuser  = rd_word[3*OUT_WIDTH];

	// a faulted beat carries zero colors
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[3*OUT_WIDTH-1:0] == '0)
		else $error("fault beat with nonzero color");

	// input is held off only while results wait at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// a finished result is kept while the pipeline is stalled
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[PIPE_LAT-1] && !en |=> vld_q[PIPE_LAT-1])
		else $error("stalled result lost");

endmodule
